FILE: sv/lcdseq_pkg.sv
// Shared types, codes and constant tables of the character LCD bus sequencer.
// No dependencies; every other file of the block imports this package.
package lcdseq_pkg;

    localparam int unsigned HOLD_W  = 20;
    localparam int unsigned PULSE_W = 16;
    localparam int unsigned CFG_W   = 20;

    // Command codes of the request
    typedef enum logic [2:0] {
        CMD_INSTR  = 3'd0,
        CMD_DATA   = 3'd1,
        CMD_CURSOR = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_INIT   = 3'd4
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FOUR_BIT   = 3'd0,
        CFG_FOUR_LINE  = 3'd1,
        CFG_PULSE      = 3'd2,
        CFG_CLEAR_WAIT = 3'd3,
        CFG_POWER_UP   = 3'd4
    } cfg_index_t;

    localparam logic                 RST_FOUR_BIT   = 1'b1;
    localparam logic                 RST_FOUR_LINE  = 1'b0;
    localparam logic [PULSE_W-1:0]   RST_PULSE      = 16'd1000;
    localparam logic [PULSE_W-1:0]   RST_CLEAR_WAIT = 16'd1000;
    localparam logic [HOLD_W-1:0]    RST_POWER_UP   = 20'd50000;

    localparam logic [7:0] INSTR_CLEAR      = 8'h01;
    localparam logic [7:0] INSTR_SET_DDRAM  = 8'h80;

    // Init program steps; the byte-bus program skips the second function set
    localparam logic [2:0] INIT_FIRST      = 3'd0;
    localparam logic [2:0] INIT_FUNC_4BIT  = 3'd1;
    localparam logic [2:0] INIT_AFTER_FUNC = 3'd2;
    localparam logic [2:0] INIT_WAIT       = 3'd4;
    localparam logic [2:0] INIT_LAST       = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PWR,
        ST_BYTE,
        ST_CWAIT
    } lcd_state_t;

    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_CLEAR,
        MODE_INIT
    } run_mode_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;        // take a new byte, restart the phase count
        logic       load_init;   // byte from the init table, else from the request
        logic [2:0] init_idx;
        logic       emit_pulse;  // put out the current phase of the byte
        logic       emit_wait;   // put out a wait phase
        logic       wait_power;  // wait is the power-up wait
        logic       last;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic byte_done;
        logic four_bit;
        logic cursor_ok;
    } sts_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic four_bit);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = four_bit ? 8'h02 : 8'h38;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h01;
            3'd5:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] line_offset(input logic [1:0] row);
        logic [7:0] off;
        unique case (row)
            2'd0: off = 8'h00;
            2'd1: off = 8'h40;
            2'd2: off = 8'h10;
            2'd3: off = 8'h50;
        endcase
        return off;
    endfunction

endpackage

FILE: sv/lcdseq_ctrl.sv
// Controller state machine of the LCD bus sequencer: walks each request's phase run.
// Depends on lcdseq_pkg; drives lcdseq_dp through ctl_t and reads sts_t back.
module lcdseq_ctrl import lcdseq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] cmd,
    input  sts_t       sts,
    output ctl_t       ctl,
    output logic       busy
);

    lcd_state_t state_reg, state_next;
    run_mode_t  mode_reg, mode_next;
    logic [2:0] prog_reg, prog_next;
    logic [2:0] step_nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_SINGLE;
            prog_reg  <= INIT_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            prog_reg  <= prog_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // next init step; the byte bus has no second function set
    assign step_nxt = (prog_reg == INIT_FIRST && !sts.four_bit) ? INIT_AFTER_FUNC
                                                               : prog_reg + 3'd1;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        prog_next  = prog_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_INSTR, CMD_DATA:
                        begin
                            ctl.load   = 1'b1;
                            mode_next  = MODE_SINGLE;
                            state_next = ST_BYTE;
                        end
                        CMD_CURSOR:
                        begin
                            if (sts.cursor_ok)
                            begin
                                ctl.load   = 1'b1;
                                mode_next  = MODE_SINGLE;
                                state_next = ST_BYTE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ctl.load   = 1'b1;
                            mode_next  = MODE_CLEAR;
                            state_next = ST_BYTE;
                        end
                        CMD_INIT:
                        begin
                            mode_next  = MODE_INIT;
                            state_next = ST_PWR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PWR:
            begin
                ctl.emit_wait  = 1'b1;
                ctl.wait_power = 1'b1;
                ctl.load       = 1'b1;
                ctl.load_init  = 1'b1;
                ctl.init_idx   = INIT_FIRST;
                prog_next      = INIT_FIRST;
                state_next     = ST_BYTE;
            end
            ST_BYTE:
            begin
                ctl.emit_pulse = 1'b1;
                if (sts.byte_done)
                begin
                    unique case (mode_reg)
                        MODE_CLEAR:
                        begin
                            state_next = ST_CWAIT;
                        end
                        MODE_INIT:
                        begin
                            if (prog_reg == INIT_LAST)
                            begin
                                ctl.last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else if (step_nxt == INIT_WAIT)
                            begin
                                prog_next  = INIT_WAIT;
                                state_next = ST_CWAIT;
                            end
                            else
                            begin
                                ctl.load      = 1'b1;
                                ctl.load_init = 1'b1;
                                ctl.init_idx  = step_nxt;
                                prog_next     = step_nxt;
                            end
                        end
                        default:
                        begin
                            ctl.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CWAIT:
            begin
                ctl.emit_wait = 1'b1;
                if (mode_reg == MODE_INIT)
                begin
                    ctl.load      = 1'b1;
                    ctl.load_init = 1'b1;
                    ctl.init_idx  = INIT_LAST;
                    prog_next     = INIT_LAST;
                    state_next    = ST_BYTE;
                end
                else
                begin
                    ctl.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: sv/lcdseq_dp.sv
// Datapath of the LCD bus sequencer: configuration registers, byte and phase
// registers and the registered phase outputs. Depends on lcdseq_pkg.
module lcdseq_dp import lcdseq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [2:0]        cmd,
    input  logic [7:0]        byte_value,
    input  logic [1:0]        row,
    input  logic [3:0]        column,
    input  ctl_t              ctl,
    output sts_t              sts,
    output logic              strobe,
    output logic              reg_select,
    output logic              enable_level,
    output logic [7:0]        bus_data,
    output logic [HOLD_W-1:0] hold_time,
    output logic              last
);

    logic               four_bit_reg;
    logic               four_line_reg;
    logic [PULSE_W-1:0] pulse_reg;
    logic [PULSE_W-1:0] clear_wait_reg;
    logic [HOLD_W-1:0]  power_up_reg;

    logic [7:0]         byte_reg, byte_next;
    logic               rs_reg, rs_next;
    logic [1:0]         phase_reg, phase_next;

    logic               strobe_reg;
    logic               rs_out_reg, en_out_reg, last_out_reg;
    logic [7:0]         data_out_reg;
    logic [HOLD_W-1:0]  hold_out_reg;

    logic [7:0]         req_byte;
    logic [7:0]         phase_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg   <= RST_FOUR_BIT;
            four_line_reg  <= RST_FOUR_LINE;
            pulse_reg      <= RST_PULSE;
            clear_wait_reg <= RST_CLEAR_WAIT;
            power_up_reg   <= RST_POWER_UP;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FOUR_BIT:   four_bit_reg   <= cfg_data[0];
                CFG_FOUR_LINE:  four_line_reg  <= cfg_data[0];
                CFG_PULSE:      pulse_reg      <= cfg_data[PULSE_W-1:0];
                CFG_CLEAR_WAIT: clear_wait_reg <= cfg_data[PULSE_W-1:0];
                CFG_POWER_UP:   power_up_reg   <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    // byte the request itself asks for
    always_comb
    begin
        unique case (cmd)
            CMD_INSTR, CMD_DATA: req_byte = byte_value;
            CMD_CURSOR:          req_byte = INSTR_SET_DDRAM | line_offset(row)
                                            | {4'b0000, column};
            CMD_CLEAR:           req_byte = INSTR_CLEAR;
            default:             req_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        phase_next = phase_reg;
        if (ctl.emit_pulse)
        begin
            phase_next = phase_reg + 2'd1;
        end
        if (ctl.load)
        begin
            byte_next  = ctl.load_init ? init_byte(ctl.init_idx, four_bit_reg) : req_byte;
            rs_next    = !ctl.load_init && (cmd == CMD_DATA);
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rs_reg   <= rs_next;
    end

    // nibble bus: high nibble on phases 0 and 1, low nibble on 2 and 3
    always_comb
    begin
        if (four_bit_reg)
        begin
            phase_data = phase_reg[1] ? {4'b0000, byte_reg[3:0]} : {4'b0000, byte_reg[7:4]};
        end
        else
        begin
            phase_data = byte_reg;
        end
    end

    assign sts.byte_done = four_bit_reg ? (phase_reg == 2'd3) : (phase_reg == 2'd1);
    assign sts.four_bit  = four_bit_reg;
    assign sts.cursor_ok = !row[1] || four_line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit_pulse || ctl.emit_wait;
        end
    end

    // payload holds between phases, so a clear wait repeats RS and data
    always_ff @(posedge clk)
    begin
        if (ctl.emit_pulse)
        begin
            rs_out_reg   <= rs_reg;
            en_out_reg   <= !phase_reg[0];
            data_out_reg <= phase_data;
            hold_out_reg <= {{(HOLD_W-PULSE_W){1'b0}}, pulse_reg};
            last_out_reg <= ctl.last;
        end
        else if (ctl.emit_wait)
        begin
            en_out_reg   <= 1'b0;
            last_out_reg <= ctl.last;
            if (ctl.wait_power)
            begin
                rs_out_reg   <= 1'b0;
                data_out_reg <= 8'h00;
                hold_out_reg <= power_up_reg;
            end
            else
            begin
                hold_out_reg <= {{(HOLD_W-PULSE_W){1'b0}}, clear_wait_reg};
            end
        end
    end

    assign strobe       = strobe_reg;
    assign reg_select   = rs_out_reg;
    assign enable_level = en_out_reg;
    assign bus_data     = data_out_reg;
    assign hold_time    = hold_out_reg;
    assign last         = last_out_reg;

endmodule

FILE: sv/char_lcd_bus_sequencer_core.sv
// Top level of the character LCD bus sequencer.
// Depends on lcdseq_pkg, lcdseq_ctrl and lcdseq_dp.
//
// Usage:
//   Request channel: drive cmd, byte_value, row and column with start high;
//   the request is taken at a rising edge where start is high and busy is low.
//   Configuration channel: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high, so a write lands at the edge where cfg_valid is high. Write
//   only while busy is low and no phase is still showing.
//   Result channel: each bus phase (reg_select, enable_level, bus_data,
//   hold_time, last) is shown for one cycle with strobe high; last marks the
//   final phase of a request's run. The receiver cannot hold phases off.
// Timing:
//   One phase leaves per clock as the controller steps through the run; the
//   request edge moves it out of idle and each phase is registered on its
//   way to the pins. Busy stays high while the run is walked, so no new
//   request is taken meanwhile. Requests that give no phases leave busy low.
// Reset:
//   rst_n low returns the controller to idle, drops strobe and reloads the
//   configuration registers with their power-on values.
module char_lcd_bus_sequencer_core import lcdseq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic [7:0]        byte_value,
    input  logic [1:0]        row,
    input  logic [3:0]        column,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              strobe,
    output logic              reg_select,
    output logic              enable_level,
    output logic [7:0]        bus_data,
    output logic [HOLD_W-1:0] hold_time,
    output logic              last
);

    ctl_t ctl;
    sts_t sts;

    // configuration writes are never held off
    assign cfg_ready = 1'b1;

    // sequence each request into byte and wait steps
    lcdseq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // hold configuration, split bytes into phases, register the pins
    lcdseq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .byte_value   (byte_value),
        .row          (row),
        .column       (column),
        .ctl          (ctl),
        .sts          (sts),
        .strobe       (strobe),
        .reg_select   (reg_select),
        .enable_level (enable_level),
        .bus_data     (bus_data),
        .hold_time    (hold_time),
        .last         (last)
    );

endmodule

FILE: sv/lcdseq_checker.sv
// Port-level checks of the LCD bus sequencer, bound to the top level.
// Depends on lcdseq_pkg for widths.
module lcdseq_checker import lcdseq_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              strobe,
    input logic              reg_select,
    input logic              enable_level,
    input logic [7:0]        bus_data,
    input logic [HOLD_W-1:0] hold_time,
    input logic              last
);

    // a run's final phase is never followed at once by another phase
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("phase right after last phase");

    // a run still under way keeps busy high
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("busy dropped inside a run");

    // EN high is followed by EN low with the same pins
    a_en_pair: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && enable_level |=> strobe && !enable_level
            && $stable(bus_data) && $stable(reg_select) && $stable(hold_time))
        else $error("EN high phase not followed by matching EN low phase");

    // nothing leaves while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !strobe)
        else $error("phase shown after idle cycle");

endmodule

bind char_lcd_bus_sequencer_core lcdseq_checker u_lcdseq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .strobe       (strobe),
    .reg_select   (reg_select),
    .enable_level (enable_level),
    .bus_data     (bus_data),
    .hold_time    (hold_time),
    .last         (last)
);

FILE: tb/char_lcd_bus_sequencer_core_tb.sv
// Self-checking testbench of the character LCD bus sequencer core.
// Depends on lcdseq_pkg and char_lcd_bus_sequencer_core; predicts every bus phase
// from its own mirror of the settings and checks each strobed phase in order.
module char_lcd_bus_sequencer_core_tb;
    import lcdseq_pkg::*;

    // Commands above init are reserved and must give no phases
    localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    // Instruction bytes of the power-up program
    localparam logic [7:0] FUNC_NIBBLE_ENTRY = 8'h02;
    localparam logic [7:0] FUNC_SET_4BIT     = 8'h28;
    localparam logic [7:0] FUNC_SET_8BIT     = 8'h38;
    localparam logic [7:0] DISPLAY_ON        = 8'h0C;
    localparam logic [7:0] ENTRY_MODE_INC    = 8'h06;

    // Rows at and above this are off the glass in two-line geometry
    localparam logic [1:0] TWO_LINE_ROWS = 2'd2;

    // Quiet time required before a register write goes out or a drain ends,
    // long enough to prove that nothing is still in flight.
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 16;

    // Watchdog limit, sized for the slowest legal run: about 600 requests, the
    // 55 % section roughly doubling the gaps, some 85 register writes that
    // each wait out the settle time, and the reset, with a wide margin.
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_CFG_WRITE,
        OP_DRAIN
    } op_kind_t;

    // One entry of the driver's work list
    typedef struct packed {
        op_kind_t         kind;
        logic [2:0]       cmd;
        logic [7:0]       byte_value;
        logic [1:0]       row;
        logic [3:0]       column;
        cfg_index_t       idx;
        logic [CFG_W-1:0] data;
        logic [6:0]       idle_pct;
    } op_t;

    // One bus phase as the block should show it
    typedef struct packed {
        logic              rs;
        logic              en;
        logic [7:0]        data;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } phase_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        cmd = CMD_INSTR;
    logic [7:0]        byte_value = '0;
    logic [1:0]        row = '0;
    logic [3:0]        column = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = CFG_FOUR_BIT;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              strobe;
    logic              reg_select;
    logic              enable_level;
    logic [7:0]        bus_data;
    logic [HOLD_W-1:0] hold_time;
    logic              last;

    op_t    pending_ops[$];
    phase_t expected_phases[$];

    // Mirror of the block's settings, updated as each write lands
    logic               mirror_four_bit;
    logic               mirror_four_line;
    logic [PULSE_W-1:0] mirror_pulse;
    logic [PULSE_W-1:0] mirror_clear_wait;
    logic [HOLD_W-1:0]  mirror_power_up;

    // Pin levels of the phase last predicted; clear waits repeat them
    logic       pin_rs;
    logic [7:0] pin_data;

    int unsigned quiet_cycles = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    logic [6:0]  sender_idle_pct = 7'd19;

    char_lcd_bus_sequencer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .byte_value   (byte_value),
        .row          (row),
        .column       (column),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .reg_select   (reg_select),
        .enable_level (enable_level),
        .bus_data     (bus_data),
        .hold_time    (hold_time),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Phase prediction
    // ---------------------------------------------------------------------
    function automatic void queue_phase(input logic rs, input logic en,
                                        input logic [7:0] data,
                                        input logic [HOLD_W-1:0] hold);
        phase_t p;
        p.rs   = rs;
        p.en   = en;
        p.data = data;
        p.hold = hold;
        p.last = 1'b0;
        expected_phases.push_back(p);
        pin_rs   = rs;
        pin_data = data;
    endfunction

    // One enable strobe: EN high, then EN low, both for the pulse time
    function automatic void queue_pulse(input logic rs, input logic [7:0] data);
        queue_phase(rs, 1'b1, data, HOLD_W'(mirror_pulse));
        queue_phase(rs, 1'b0, data, HOLD_W'(mirror_pulse));
    endfunction

    // Nibble bus: high nibble then low nibble on the low four pins; byte bus: one strobe
    function automatic void queue_byte(input logic rs, input logic [7:0] value);
        if (mirror_four_bit)
        begin
            queue_pulse(rs, {4'h0, value[7:4]});
            queue_pulse(rs, {4'h0, value[3:0]});
        end
        else
        begin
            queue_pulse(rs, value);
        end
    endfunction

    function automatic void queue_wait(input logic [HOLD_W-1:0] hold);
        queue_phase(pin_rs, 1'b0, pin_data, hold);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: work through pending_ops, one request or write at a time.
    // A held request stays on the pins until the block takes it; a register
    // write goes out only once the block has been quiet for a while.
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        int unsigned phases_before;
        phase_t      closing;
        logic [7:0]  line_base;
        logic        taken;

        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= CMD_INSTR;
            byte_value <= '0;
            row        <= '0;
            column     <= '0;
            cfg_valid  <= 1'b0;
            cfg_index  <= CFG_FOUR_BIT;
            cfg_data   <= '0;
            mirror_four_bit   = RST_FOUR_BIT;
            mirror_four_line  = RST_FOUR_LINE;
            mirror_pulse      = RST_PULSE;
            mirror_clear_wait = RST_CLEAR_WAIT;
            mirror_power_up   = RST_POWER_UP;
            quiet_cycles      = 0;
        end
        else
        begin
            taken = 1'b0;

            if (start && !busy)
            begin
                // Request taken at this edge: predict its whole run of phases
                taken = 1'b1;
                phases_before = expected_phases.size();
                pin_rs   = 1'b0;
                pin_data = '0;
                case (cmd)
                    CMD_INSTR: queue_byte(1'b0, byte_value);
                    CMD_DATA:  queue_byte(1'b1, byte_value);
                    CMD_CURSOR:
                    begin
                        // Lower two lines exist only in four-line geometry
                        if (row < TWO_LINE_ROWS || mirror_four_line)
                        begin
                            case (row)
                                2'd0:    line_base = 8'h00;
                                2'd1:    line_base = 8'h40;
                                2'd2:    line_base = 8'h10;
                                default: line_base = 8'h50;
                            endcase
                            queue_byte(1'b0, INSTR_SET_DDRAM | line_base | {4'h0, column});
                        end
                    end
                    CMD_CLEAR:
                    begin
                        queue_byte(1'b0, INSTR_CLEAR);
                        queue_wait(HOLD_W'(mirror_clear_wait));
                    end
                    CMD_INIT:
                    begin
                        // Power-up wait with all pins low, then the set-up program
                        queue_phase(1'b0, 1'b0, 8'h00, mirror_power_up);
                        if (mirror_four_bit)
                        begin
                            queue_byte(1'b0, FUNC_NIBBLE_ENTRY);
                            queue_byte(1'b0, FUNC_SET_4BIT);
                        end
                        else
                        begin
                            queue_byte(1'b0, FUNC_SET_8BIT);
                        end
                        queue_byte(1'b0, DISPLAY_ON);
                        queue_byte(1'b0, INSTR_CLEAR);
                        queue_wait(HOLD_W'(mirror_clear_wait));
                        queue_byte(1'b0, ENTRY_MODE_INC);
                    end
                    default: ;
                endcase
                // Flag the closing phase of this run, if there is one
                if (expected_phases.size() > phases_before)
                begin
                    closing = expected_phases.pop_back();
                    closing.last = 1'b1;
                    expected_phases.push_back(closing);
                end
                void'(pending_ops.pop_front());
            end
            else if (cfg_valid && cfg_ready)
            begin
                taken = 1'b1;
                case (cfg_index)
                    CFG_FOUR_BIT:   mirror_four_bit   = cfg_data[0];
                    CFG_FOUR_LINE:  mirror_four_line  = cfg_data[0];
                    CFG_PULSE:      mirror_pulse      = cfg_data[PULSE_W-1:0];
                    CFG_CLEAR_WAIT: mirror_clear_wait = cfg_data[PULSE_W-1:0];
                    CFG_POWER_UP:   mirror_power_up   = cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
                void'(pending_ops.pop_front());
            end

            // Count cycles with nothing owed, nothing showing and nothing offered
            if (expected_phases.size() == 0 && !busy && !strobe && !start && !cfg_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            // Hold whatever is still on offer; otherwise pick the next step
            if (taken || !(start || cfg_valid))
            begin
                if (pending_ops.size() == 0)
                begin
                    start     <= 1'b0;
                    cfg_valid <= 1'b0;
                end
                else
                begin
                    case (pending_ops[0].kind)
                        OP_REQUEST:
                        begin
                            cfg_valid <= 1'b0;
                            if ($urandom_range(0, 99) < pending_ops[0].idle_pct)
                            begin
                                start <= 1'b0;
                            end
                            else
                            begin
                                start      <= 1'b1;
                                cmd        <= pending_ops[0].cmd;
                                byte_value <= pending_ops[0].byte_value;
                                row        <= pending_ops[0].row;
                                column     <= pending_ops[0].column;
                            end
                        end
                        OP_CFG_WRITE:
                        begin
                            start <= 1'b0;
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                cfg_valid <= 1'b1;
                                cfg_index <= pending_ops[0].idx;
                                cfg_data  <= pending_ops[0].data;
                            end
                            else
                            begin
                                cfg_valid <= 1'b0;
                            end
                        end
                        default:
                        begin
                            // Drain: hold off until every owed phase has shown
                            start     <= 1'b0;
                            cfg_valid <= 1'b0;
                            if (quiet_cycles >= SETTLE_CYCLES)
                                void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: sample mid-cycle, so the expectation store is never touched
    // by the driver and the monitor in the same time step. A strobed phase
    // is stable from one rising edge to the next.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : monitor
        phase_t want;

        if (rst_n === 1'b1 && strobe !== 1'b0)
        begin
            if (expected_phases.size() == 0)
            begin
                $error("phase shown with none owed: rs %0h en %0h data %0h hold %0h last %0h",
                       reg_select, enable_level, bus_data, hold_time, last);
                fail_count++;
            end
            else
            begin
                want = expected_phases.pop_front();
                if (reg_select !== want.rs)
                begin
                    $error("reg_select: expected %0h, got %0h", want.rs, reg_select);
                    fail_count++;
                end
                if (enable_level !== want.en)
                begin
                    $error("enable_level: expected %0h, got %0h", want.en, enable_level);
                    fail_count++;
                end
                if (bus_data !== want.data)
                begin
                    $error("bus_data: expected %0h, got %0h", want.data, bus_data);
                    fail_count++;
                end
                if (hold_time !== want.hold)
                begin
                    $error("hold_time: expected %0h, got %0h", want.hold, hold_time);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0h, got %0h", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Work list builders
    // ---------------------------------------------------------------------
    task automatic add_request(input logic [2:0] c, input logic [7:0] b,
                               input logic [1:0] r, input logic [3:0] col);
        op_t o;
        o            = '0;
        o.kind       = OP_REQUEST;
        o.cmd        = c;
        o.byte_value = b;
        o.row        = r;
        o.column     = col;
        o.idle_pct   = sender_idle_pct;
        pending_ops.push_back(o);
    endtask

    task automatic add_write(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        op_t o;
        o      = '0;
        o.kind = OP_CFG_WRITE;
        o.idx  = idx;
        o.data = data;
        pending_ops.push_back(o);
    endtask

    task automatic add_drain();
        op_t o;
        o      = '0;
        o.kind = OP_DRAIN;
        pending_ops.push_back(o);
    endtask

    // Tick count of w bits, often an extreme; bits above w are junk the block drops
    function automatic logic [CFG_W-1:0] pick_ticks(input int unsigned w);
        logic [CFG_W-1:0] field_mask;
        logic [CFG_W-1:0] v;
        field_mask = (CFG_W'(1) << w) - CFG_W'(1);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = CFG_W'(1);
            2:       v = field_mask;
            default: v = CFG_W'($urandom) & field_mask;
        endcase
        return v | (CFG_W'($urandom) & ~field_mask);
    endfunction

    task automatic add_random_settings();
        add_write(CFG_FOUR_BIT, CFG_W'($urandom));
        add_write(CFG_FOUR_LINE, CFG_W'($urandom));
        add_write(CFG_PULSE, pick_ticks(PULSE_W));
        add_write(CFG_CLEAR_WAIT, pick_ticks(PULSE_W));
        add_write(CFG_POWER_UP, pick_ticks(HOLD_W));
    endtask

    // Mostly real commands; a few reserved codes and off-glass cursor moves
    task automatic add_random_items(input int unsigned target);
        int unsigned useful;
        int unsigned pick;
        logic [2:0]  c;
        logic [1:0]  r;
        useful = 0;
        while (useful < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c = CMD_INSTR;
            else if (pick < 60)
                c = CMD_DATA;
            else if (pick < 80)
                c = CMD_CURSOR;
            else if (pick < 87)
                c = CMD_CLEAR;
            else if (pick < 93)
                c = CMD_INIT;
            else
                c = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
            r = 2'($urandom);
            add_request(c, 8'($urandom), r, 4'($urandom));
            if (c <= CMD_INIT && !(c == CMD_CURSOR && r >= TWO_LINE_ROWS))
            begin
                useful++;
                if (useful % 40 == 0)
                    add_random_settings();
                else if ($urandom_range(0, 29) == 0)
                    add_drain();
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;

        // Directed: power-on settings, nibble bus, two-line map
        sender_idle_pct = 7'd19;
        add_request(CMD_INSTR, 8'h00, 2'd0, 4'd0);
        add_request(CMD_DATA, 8'hFF, 2'd3, 4'd15);
        add_request(CMD_CURSOR, 8'h00, 2'd0, 4'd0);
        add_request(CMD_CURSOR, 8'h00, 2'd1, 4'd15);
        add_request(CMD_CURSOR, 8'h00, 2'd2, 4'd3);
        add_request(CMD_CURSOR, 8'hFF, 2'd3, 4'd15);
        add_request(CMD_CLEAR, 8'h00, 2'd0, 4'd0);
        add_request(CMD_INIT, 8'h00, 2'd0, 4'd0);
        add_request(CMD_RESERVED_LO, 8'hFF, 2'd1, 4'd1);
        add_request(CMD_RESERVED_HI, 8'h00, 2'd0, 4'd0);
        add_drain();

        // Byte bus with all eight pins, four-line map, zero pulse and clear waits, longest power-up wait
        add_write(CFG_FOUR_BIT, CFG_W'(1'b0));
        add_write(CFG_FOUR_LINE, CFG_W'(1'b1));
        add_write(CFG_PULSE, '0);
        add_write(CFG_CLEAR_WAIT, '0);
        add_write(CFG_POWER_UP, '1);
        add_request(CMD_DATA, 8'h80, 2'd0, 4'd0);
        add_request(CMD_INSTR, 8'h7F, 2'd0, 4'd0);
        add_request(CMD_CURSOR, 8'h00, 2'd2, 4'd7);
        add_request(CMD_CURSOR, 8'h00, 2'd3, 4'd15);
        add_request(CMD_CLEAR, 8'h00, 2'd0, 4'd0);
        add_request(CMD_INIT, 8'h00, 2'd0, 4'd0);

        // Back to the nibble bus with the longest pulse and clear waits
        add_write(CFG_FOUR_BIT, CFG_W'(1'b1));
        add_write(CFG_PULSE, CFG_W'(16'hFFFF));
        add_write(CFG_CLEAR_WAIT, CFG_W'(16'hFFFF));
        add_write(CFG_POWER_UP, '0);
        add_request(CMD_INIT, 8'h00, 2'd0, 4'd0);
        add_request(CMD_DATA, 8'hA5, 2'd0, 4'd0);
        add_request(CMD_CURSOR, 8'h00, 2'd3, 4'd0);
        add_request(CMD_CLEAR, 8'h00, 2'd0, 4'd0);
        add_request(CMD_INSTR, 8'h5A, 2'd0, 4'd0);

        // Random: sparse gaps, then heavy gaps, then back to back
        add_random_settings();
        add_random_items(160);
        sender_idle_pct = 7'd55;
        add_drain();
        add_random_settings();
        add_random_items(160);
        sender_idle_pct = 7'd0;
        add_random_settings();
        add_random_items(160);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every owed phase to show,
        // then give stray phases time to surface.
        while (pending_ops.size() != 0 || expected_phases.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_phases.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lcdseq_pkg.sv
sv/lcdseq_ctrl.sv
sv/lcdseq_dp.sv
sv/char_lcd_bus_sequencer_core.sv
sv/lcdseq_checker.sv
tb/char_lcd_bus_sequencer_core_tb.sv
